@@ sv/tsw_pkg.sv @@
// ----------------------------------------------------------------------------
// tsw_pkg: shared types and constants of the texture sampler
// Field widths, register indexes, mode codes and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package tsw_pkg;

    // parameter defaults
    localparam int MAX_DIM_DEF         = 256;
    localparam int CHANNEL_BITS_DEF    = 16;
    localparam int COORD_FRAC_BITS_DEF = 16;

    // fixed port field widths
    localparam int COORD_W    = 24;
    localparam int TXY_W      = 8;
    localparam int FIELD_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BORDER = 2'd0,
        REG_FILTER = 2'd1,
        REG_WIDTH  = 2'd2,
        REG_HEIGHT = 2'd3
    } reg_idx_t;

    localparam logic [1:0] BORDER_REPEAT = 2'd0;
    localparam logic [1:0] BORDER_MIRROR = 2'd1;
    localparam logic [1:0] BORDER_CLAMP  = 2'd2;

    localparam logic FILTER_NEAREST  = 1'b0;
    localparam logic FILTER_BILINEAR = 1'b1;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [CFG_DATA_W-1:0] DIM_RESET = 9'd256;

    typedef struct packed {
        logic [1:0] border;
        logic       filter;
    } mode_t;

endpackage

`default_nettype wire

@@ sv/tsw_req_if.sv @@
// ----------------------------------------------------------------------------
// tsw_req_if: request channel of the texture sampler
// Valid/ready handshake with texel write and sample payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsw_req_if
    import tsw_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic [TXY_W-1:0]           texel_x;
    logic [TXY_W-1:0]           texel_y;
    logic [FIELD_W-1:0]         texel_red;
    logic [FIELD_W-1:0]         texel_green;
    logic [FIELD_W-1:0]         texel_blue;
    logic signed [COORD_W-1:0]  coord_u;
    logic signed [COORD_W-1:0]  coord_v;

    modport source (output valid, op, texel_x, texel_y, texel_red, texel_green,
                    texel_blue, coord_u, coord_v, input ready);
    modport sink   (input valid, op, texel_x, texel_y, texel_red, texel_green,
                    texel_blue, coord_u, coord_v, output ready);
endinterface

`default_nettype wire

@@ sv/tsw_rsp_if.sv @@
// ----------------------------------------------------------------------------
// tsw_rsp_if: result channel of the texture sampler
// Valid/ready handshake carrying one sampled RGB texel.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsw_rsp_if
    import tsw_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] out_red;
    logic [FIELD_W-1:0] out_green;
    logic [FIELD_W-1:0] out_blue;

    modport source (output valid, out_red, out_green, out_blue, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

`default_nettype wire

@@ sv/tsw_ram.sv @@
// ----------------------------------------------------------------------------
// tsw_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module tsw_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16384
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

`default_nettype wire

@@ sv/tsw_axis.sv @@
// ----------------------------------------------------------------------------
// tsw_axis: coordinate path of one axis
// Border mapping, scale by image size, texel index and fraction extraction.
// ----------------------------------------------------------------------------
`default_nettype none

module tsw_axis
    import tsw_pkg::*;
#(
    parameter int MAX_DIM         = MAX_DIM_DEF,
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               adv,
    input  wire mode_t                              mode,
    input  wire logic [$clog2(MAX_DIM+1)-1:0]       dim,
    input  wire logic signed [COORD_W-1:0]          coord,
    output      logic [$clog2(MAX_DIM)-1:0]         idx0,
    output      logic [$clog2(MAX_DIM)-1:0]         idx1,
    output      logic [COORD_FRAC_BITS-1:0]         frac
);
    localparam int F  = COORD_FRAC_BITS;
    localparam int DW = $clog2(MAX_DIM+1);
    localparam int XW = $clog2(MAX_DIM);
    localparam int PW = F + 1 + DW;
    localparam int EW = COORD_W + F + 2;

    logic signed [EW-1:0] s_ext;
    logic signed [EW-1:0] one_s;
    logic [F:0]           one_t;
    logic [F:0]           t_next;
    logic [F:0]           t_reg;
    logic [DW-1:0]        mult;
    logic [PW-1:0]        p_next;
    logic [PW-1:0]        p_reg;
    logic [DW-1:0]        dmax;
    logic [PW-F-1:0]      a_raw;
    logic [DW-1:0]        a_c;

    assign s_ext = EW'(coord);
    assign one_s = $signed(EW'(1) << F);
    assign one_t = (F+1)'(1) << F;

    // stage 1: fold coordinate into [0, one]
    always_comb
    begin
        case (mode.border)
            BORDER_REPEAT: t_next = {1'b0, s_ext[F-1:0]};
            BORDER_MIRROR:
            begin
                if (s_ext[F])
                    t_next = one_t - {1'b0, s_ext[F-1:0]};
                else
                    t_next = {1'b0, s_ext[F-1:0]};
            end
            default:
            begin
                if (s_ext < 0)
                    t_next = '0;
                else if (s_ext >= one_s)
                    t_next = one_t;
                else
                    t_next = s_ext[F:0];
            end
        endcase
    end

    // stage 2: scale by size (nearest) or size minus one (bilinear)
    assign dmax   = dim - DW'(1);
    assign mult   = (mode.filter == FILTER_BILINEAR) ? dmax : dim;
    assign p_next = PW'(t_reg) * PW'(mult);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg <= t_next;
            p_reg <= p_next;
        end
    end

    // index with edge clamp
    assign a_raw = p_reg[PW-1:F];
    assign a_c   = (a_raw > (PW-F)'(dmax)) ? dmax : a_raw[DW-1:0];

    always_comb
    begin
        idx0 = XW'(a_c);
        if (mode.filter == FILTER_BILINEAR)
        begin
            idx1 = (a_c == dmax) ? XW'(a_c) : XW'(a_c + DW'(1));
            frac = p_reg[F-1:0];
        end
        else
        begin
            idx1 = XW'(a_c);
            frac = '0;
        end
    end
endmodule

`default_nettype wire

@@ sv/tsw_blend.sv @@
// ----------------------------------------------------------------------------
// tsw_blend: weighted sum of four corner texels
// Registered weight-times-texel products, then truncated channel sums.
// ----------------------------------------------------------------------------
`default_nettype none

module tsw_blend
    import tsw_pkg::*;
#(
    parameter int CHANNEL_BITS    = CHANNEL_BITS_DEF,
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
    input  wire logic                                       clk,
    input  wire logic                                       adv,
    input  wire logic [3:0][COORD_FRAC_BITS:0]              wt,
    input  wire logic [3:0][2:0][CHANNEL_BITS-1:0]          tex,
    output      logic [2:0][CHANNEL_BITS-1:0]               chan
);
    localparam int F  = COORD_FRAC_BITS;
    localparam int C  = CHANNEL_BITS;
    localparam int QW = F + 1 + C;
    localparam int SW = QW + 2;

    logic [3:0][2:0][QW-1:0] prod_reg;
    logic [2:0][SW-1:0]      sum;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_reg[k][c] <= QW'(wt[k]) * QW'(tex[k][c]);
                end
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sum[c]  = SW'(prod_reg[0][c]) + SW'(prod_reg[1][c])
                    + SW'(prod_reg[2][c]) + SW'(prod_reg[3][c]);
            chan[c] = sum[c][F+C-1:F];
        end
    end
endmodule

`default_nettype wire

@@ sv/texture_sampler_wrap_bilinear_core.sv @@
// ----------------------------------------------------------------------------
// texture_sampler_wrap_bilinear_core: bilinear texture sampler with wrap modes
// Texel store in four parity banks; nearest or bilinear sampling with repeat,
// mirror and clamp border handling.
// ----------------------------------------------------------------------------
//  channel | dir | handshake        | payload
//  --------+-----+------------------+------------------------------------------
//  req     | in  | valid/ready      | op, texel_x/y, texel_red/green/blue,
//          |     |                  | coord_u, coord_v
//  rsp     | out | valid/ready      | out_red, out_green, out_blue
//  cfg     | in  | cfg_we (no wait) | cfg_index, cfg_data
//
//  One request per cycle unless the output stalls. A sample request's result
//  leaves the output register after stages 1 to 5; a write request updates
//  the store from stage 2 and gives no result. Every stage advances together,
//  held only while the output register holds a result not yet taken. Reset
//  clears valid bits and config registers; the texel store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module texture_sampler_wrap_bilinear_core
    import tsw_pkg::*;
#(
    parameter int MAX_DIM         = MAX_DIM_DEF,
    parameter int CHANNEL_BITS    = CHANNEL_BITS_DEF,
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    tsw_req_if.sink                    req,
    tsw_rsp_if.source                  rsp,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);
    localparam int F  = COORD_FRAC_BITS;
    localparam int C  = CHANNEL_BITS;
    localparam int DW = $clog2(MAX_DIM+1);
    localparam int XW = $clog2(MAX_DIM);
    localparam int HW = (XW > 1) ? XW - 1 : 1;   // bank row/column bits
    localparam int AW = 2 * HW;
    localparam int BD = 1 << AW;                 // bank depth
    localparam int TW = 3 * C;

    // ---------------- configuration ----------------
    logic [1:0]            border_reg;
    logic                  filter_reg;
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    mode_t                 mode;
    logic [DW-1:0]         dim_w;
    logic [DW-1:0]         dim_h;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            border_reg <= BORDER_REPEAT;
            filter_reg <= FILTER_NEAREST;
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_BORDER: border_reg <= cfg_data[1:0];
                REG_FILTER: filter_reg <= cfg_data[0];
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                default:    border_reg <= border_reg;
            endcase
        end
    end

    assign mode = '{border: border_reg, filter: filter_reg};

    // size zero counts as one, above the store counts as the store size
    always_comb
    begin
        if (width_reg == '0)
            dim_w = DW'(1);
        else if (32'(width_reg) > MAX_DIM)
            dim_w = DW'(MAX_DIM);
        else
            dim_w = DW'(width_reg);

        if (height_reg == '0)
            dim_h = DW'(1);
        else if (32'(height_reg) > MAX_DIM)
            dim_h = DW'(MAX_DIM);
        else
            dim_h = DW'(height_reg);
    end

    // ---------------- pipeline control ----------------
    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, vo_reg;
    logic op1_reg, op2_reg;

    // whole pipe moves unless a finished result is waiting
    assign adv       = !vo_reg || rsp.ready;
    assign req.ready = adv;
    assign rsp.valid = vo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= req.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg && (op2_reg == OP_SAMPLE);   // writes drop out here
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            vo_reg <= v5_reg;
        end
    end

    // ---------------- write request path (stages 1-2) ----------------
    logic          inr_next;
    logic          inr1_reg, inr2_reg;
    logic [XW-1:0] wx1_reg, wy1_reg, wx2_reg, wy2_reg;
    logic [TW-1:0] wd1_reg, wd2_reg;

    // writes outside the store are dropped
    assign inr_next = (32'(req.texel_x) < MAX_DIM) && (32'(req.texel_y) < MAX_DIM);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op1_reg  <= req.op;
            inr1_reg <= inr_next;
            wx1_reg  <= XW'(req.texel_x);
            wy1_reg  <= XW'(req.texel_y);
            wd1_reg  <= {C'(req.texel_blue), C'(req.texel_green), C'(req.texel_red)};
            op2_reg  <= op1_reg;
            inr2_reg <= inr1_reg;
            wx2_reg  <= wx1_reg;
            wy2_reg  <= wy1_reg;
            wd2_reg  <= wd1_reg;
        end
    end

    // ---------------- coordinate paths (stages 1-2) ----------------
    logic [XW-1:0] x0, x1, y0, y1;
    logic [F-1:0]  fu, fv;

    tsw_axis #(
        .MAX_DIM         (MAX_DIM),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_axis_u (
        .clk   (clk),
        .adv   (adv),
        .mode  (mode),
        .dim   (dim_w),
        .coord (req.coord_u),
        .idx0  (x0),
        .idx1  (x1),
        .frac  (fu)
    );

    tsw_axis #(
        .MAX_DIM         (MAX_DIM),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_axis_v (
        .clk   (clk),
        .adv   (adv),
        .mode  (mode),
        .dim   (dim_h),
        .coord (req.coord_v),
        .idx0  (y0),
        .idx1  (y1),
        .frac  (fv)
    );

    // ---------------- bank access (stage 2 -> 3) ----------------
    // Bank {py,px} holds texels with y parity py and x parity px, so the
    // four corners of a bilinear footprint land in distinct banks unless
    // an index was edge-clamped (x1 == x0); its fraction is then zero, so the
    // duplicate corner read from the same bank carries zero weight.
    logic [3:0][TW-1:0] bank_rd;
    logic [F:0]         one_t;
    logic [F:0]         ou, ov;
    logic [3:0][F:0]    wt_next;
    logic [3:0][F:0]    wt3_reg, wt4_reg;
    logic [3:0]         par_next, par3_reg;
    logic [2*F+1:0]     wp00, wp01, wp10, wp11;

    assign one_t = (F+1)'(1) << F;
    assign ou    = one_t - {1'b0, fu};
    assign ov    = one_t - {1'b0, fv};
    assign wp00  = (2*F+2)'(ou) * (2*F+2)'(ov);
    assign wp01  = (2*F+2)'(ou) * (2*F+2)'(fv);
    assign wp10  = (2*F+2)'(fu) * (2*F+2)'(ov);
    assign wp11  = (2*F+2)'(fu) * (2*F+2)'(fv);

    // corner order: (x0,y0), (x0,y1), (x1,y0), (x1,y1)
    assign wt_next[0] = wp00[2*F:F];
    assign wt_next[1] = wp01[2*F:F];
    assign wt_next[2] = wp10[2*F:F];
    assign wt_next[3] = wp11[2*F:F];
    assign par_next   = {y1[0], x1[0], y0[0], x0[0]};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wt3_reg  <= wt_next;
            par3_reg <= par_next;
        end
    end

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        localparam logic PX = ((b & 1) != 0);
        localparam logic PY = ((b & 2) != 0);

        logic [XW-1:0] col, row;
        logic [AW-1:0] raddr, waddr;
        logic          we;

        assign col   = (x0[0] == PX) ? x0 : x1;
        assign row   = (y0[0] == PY) ? y0 : y1;
        assign raddr = {HW'(row >> 1), HW'(col >> 1)};
        assign waddr = {HW'(wy2_reg >> 1), HW'(wx2_reg >> 1)};
        assign we    = adv && v2_reg && (op2_reg == OP_WRITE) && inr2_reg
                    && (wx2_reg[0] == PX) && (wy2_reg[0] == PY);

        tsw_ram #(
            .WIDTH (TW),
            .DEPTH (BD)
        ) u_ram (
            .clk   (clk),
            .we    (we),
            .waddr (waddr),
            .wdata (wd2_reg),
            .re    (adv),
            .raddr (raddr),
            .rdata (bank_rd[b])
        );
    end

    // ---------------- corner select (stage 3 -> 4) ----------------
    logic [3:0][2:0][C-1:0] tex_next, tex4_reg;

    always_comb
    begin
        tex_next[0] = bank_rd[{par3_reg[1], par3_reg[0]}];
        tex_next[1] = bank_rd[{par3_reg[3], par3_reg[0]}];
        tex_next[2] = bank_rd[{par3_reg[1], par3_reg[2]}];
        tex_next[3] = bank_rd[{par3_reg[3], par3_reg[2]}];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tex4_reg <= tex_next;
            wt4_reg  <= wt3_reg;
        end
    end

    // ---------------- blend (stage 5) and output register ----------------
    logic [2:0][C-1:0] chan;
    logic [2:0][C-1:0] out_reg;

    tsw_blend #(
        .CHANNEL_BITS    (CHANNEL_BITS),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_blend (
        .clk  (clk),
        .adv  (adv),
        .wt   (wt4_reg),
        .tex  (tex4_reg),
        .chan (chan)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= chan;
        end
    end

    assign rsp.out_red   = FIELD_W'(out_reg[0]);
    assign rsp.out_green = FIELD_W'(out_reg[1]);
    assign rsp.out_blue  = FIELD_W'(out_reg[2]);
endmodule

`default_nettype wire

@@ test/tb_tsw_if.sv @@
// ----------------------------------------------------------------------------
// tb_tsw_if: testbench-side copy of the sampler channels
// Not needed: the RTL interfaces are used directly.
// ----------------------------------------------------------------------------

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the texture sampler
// Loads texels, samples them through every border and filter mode, and checks
// each result against an in-bench predictor of the sampling arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import tsw_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    tsw_req_if req ();
    tsw_rsp_if rsp ();

    texture_sampler_wrap_bilinear_core dut (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    localparam longint ONE = 64'd1 << 16;
    localparam int REGION = 16;      // texels written up front, REGION x REGION

    typedef struct packed {
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
    } rgb_t;

    // predictor state
    rgb_t texels [int];          // written entries only
    logic [1:0] border_q = BORDER_REPEAT;
    logic filter_q = FILTER_NEAREST;
    logic [8:0] width_q = DIM_RESET;
    logic [8:0] height_q = DIM_RESET;

    rgb_t expected_rgb [$];
    int errors = 0;
    int rsp_stall_max = 3;       // receiver stall ceiling, varied per phase

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic longint eff_size(logic [8:0] raw);
        if (raw == 0) return 1;
        if (raw > 256) return 256;
        return raw;
    endfunction

    // border handling: map Q8.16 coordinate to t in [0, ONE]
    function automatic longint wrap_coord(logic signed [23:0] c);
        longint s;
        longint frac;
        bit odd;
        s = c;
        frac = s & (ONE - 1);
        odd = s[16];
        if (border_q == BORDER_REPEAT) return frac;
        if (border_q == BORDER_MIRROR) return odd ? ONE - frac : frac;
        if (s < 0) return 0;        // clamp, and unused mode 3
        if (s >= ONE) return ONE;
        return s;
    endfunction

    function automatic rgb_t fetch(longint x, longint y);
        int a;
        a = int'(y * 256 + x);
        return texels.exists(a) ? texels[a] : '0;
    endfunction

    function automatic rgb_t sampled_texel(logic signed [23:0] u, logic signed [23:0] v);
        longint w, h, tu, tv, x, y, x0, x1, y0, y1, fu, fv, pu, pv, wt[4], r, g, b;
        rgb_t c[4];
        rgb_t o;
        w = eff_size(width_q);
        h = eff_size(height_q);
        tu = wrap_coord(u);
        tv = wrap_coord(v);
        if (filter_q == FILTER_NEAREST) begin
            x = (tu * w) >> 16;
            if (x > w - 1) x = w - 1;
            y = (tv * h) >> 16;
            if (y > h - 1) y = h - 1;
            return fetch(x, y);
        end
        pu = tu * (w - 1);
        pv = tv * (h - 1);
        x0 = pu >> 16;
        y0 = pv >> 16;
        if (x0 > w - 1) x0 = w - 1;
        if (y0 > h - 1) y0 = h - 1;
        x1 = (x0 + 1 > w - 1) ? w - 1 : x0 + 1;   // edge clamp of +1 neighbour
        y1 = (y0 + 1 > h - 1) ? h - 1 : y0 + 1;
        fu = pu & (ONE - 1);
        fv = pv & (ONE - 1);
        wt[0] = ((ONE - fu) * (ONE - fv)) >> 16;
        wt[1] = ((ONE - fu) * fv) >> 16;
        wt[2] = (fu * (ONE - fv)) >> 16;
        wt[3] = (fu * fv) >> 16;
        c[0] = fetch(x0, y0);
        c[1] = fetch(x0, y1);
        c[2] = fetch(x1, y0);
        c[3] = fetch(x1, y1);
        r = 0; g = 0; b = 0;
        for (int k = 0; k < 4; k++) begin
            r += wt[k] * c[k].r;
            g += wt[k] * c[k].g;
            b += wt[k] * c[k].b;
        end
        o.r = 16'(r >> 16);
        o.g = 16'(g >> 16);
        o.b = 16'(b >> 16);
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    bit no_gaps = 1'b0;

    // one request; predictor updated at acceptance
    task automatic send_req(logic op, logic [7:0] x, logic [7:0] y, rgb_t t,
                            logic signed [23:0] u, logic signed [23:0] v);
        int gap;
        gap = no_gaps ? 0 : gap_len();
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid <= 1'b1;
        req.op <= op;
        req.texel_x <= x;
        req.texel_y <= y;
        req.texel_red <= t.r;
        req.texel_green <= t.g;
        req.texel_blue <= t.b;
        req.coord_u <= u;
        req.coord_v <= v;
        do @(posedge clk); while (!req.ready);
        if (op == OP_WRITE)
            texels[int'(y) * 256 + int'(x)] = t;
        else
            expected_rgb.push_back(sampled_texel(u, v));
        @(negedge clk);
    endtask

    task automatic write_texel(int x, int y, rgb_t t);
        send_req(OP_WRITE, x[7:0], y[7:0], t, 24'($urandom()), 24'($urandom()));
    endtask

    task automatic sample_at(logic signed [23:0] u, logic signed [23:0] v);
        rgb_t junk;
        junk = 48'({$urandom(), $urandom()});
        send_req(OP_SAMPLE, 8'($urandom()), 8'($urandom()), junk, u, v);
    endtask

    // wait for the pipe to drain, so a register can be written safely
    task automatic drain();
        req.valid <= 1'b0;
        while (expected_rgb.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);   // let trailing writes reach the store
    endtask

    task automatic set_reg(reg_idx_t idx, logic [8:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_BORDER: border_q = val[1:0];
            REG_FILTER: filter_q = val[0];
            REG_WIDTH:  width_q = val;
            default:    height_q = val;
        endcase
    endtask

    task automatic set_modes(logic [1:0] bm, logic fm, logic [8:0] w, logic [8:0] h);
        drain();
        set_reg(REG_BORDER, {7'd0, bm});
        set_reg(REG_FILTER, {8'd0, fm});
        set_reg(REG_WIDTH, w);
        set_reg(REG_HEIGHT, h);
    endtask

    function automatic rgb_t rand_rgb();
        rgb_t t;
        int p;
        t = 48'({$urandom(), $urandom()});
        p = $urandom_range(0, 9);
        if (p == 0) t = '1;
        else if (p == 1) t = '0;
        return t;
    endfunction

    // coordinate: mostly in a few lattice cells, sometimes anywhere
    function automatic logic signed [23:0] rand_coord();
        int p;
        p = $urandom_range(0, 9);
        if (p < 6) return 24'($signed($urandom_range(0, 6 * 65536)) - 3 * 65536);
        if (p < 8) return 24'($urandom());
        if (p == 8) return 24'sh7FFFFF;
        return 24'sh800000;
    endfunction

    // ------------------------------------------------------------------------
    // result checker: receiver stalls at random
    // ------------------------------------------------------------------------
    initial begin
        rsp.ready = 1'b0;
        forever begin
            @(negedge clk);
            if ($urandom_range(0, 60) == 0) begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(5, 25)) @(negedge clk);
                rsp.ready <= 1'b1;
            end else if ($urandom_range(0, 3) == 0)
                rsp.ready <= 1'b0;
            else
                rsp.ready <= ($urandom_range(0, rsp_stall_max) == 0) ? 1'b0 : 1'b1;
        end
    end

    always @(posedge clk) begin
        rgb_t e;
        if (rst_n && rsp.valid && rsp.ready) begin
            if (expected_rgb.size() == 0) begin
                $display("%0t: unexpected result expected none actual %h %h %h",
                         $time, rsp.out_red, rsp.out_green, rsp.out_blue);
                errors++;
            end else begin
                e = expected_rgb.pop_front();
                if (rsp.out_red !== e.r) begin
                    $display("%0t: red expected %h actual %h", $time, e.r, rsp.out_red);
                    errors++;
                end
                if (rsp.out_green !== e.g) begin
                    $display("%0t: green expected %h actual %h", $time, e.g, rsp.out_green);
                    errors++;
                end
                if (rsp.out_blue !== e.b) begin
                    $display("%0t: blue expected %h actual %h", $time, e.b, rsp.out_blue);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // corner region of the image; random phases keep their sizes inside it
    task automatic test_fill_store();
        no_gaps = 1'b1;
        for (int y = 0; y < REGION; y++)
            for (int x = 0; x < REGION; x++)
                write_texel(x, y, rand_rgb());
        no_gaps = 1'b0;
    endtask

    task automatic test_directed();
        rgb_t t;
        t = '1;
        write_texel(255, 255, t);
        t = '0;
        write_texel(0, 0, t);
        write_texel(0, 255, 48'h0123_4567_89AB);
        // every texel the full-size samples below touch
        write_texel(255, 0, rand_rgb());
        write_texel(255, 1, rand_rgb());
        write_texel(127, 127, rand_rgb());
        write_texel(127, 128, rand_rgb());
        write_texel(128, 127, rand_rgb());
        write_texel(128, 128, rand_rgb());
        write_texel(0, 127, rand_rgb());
        write_texel(0, 128, rand_rgb());
        write_texel(0, 192, rand_rgb());
        // reset config: repeat, nearest, 256x256
        sample_at(24'sh000000, 24'sh000000);
        sample_at(24'sh7FFFFF, 24'sh800000);
        sample_at(24'sh00FFFF, 24'sh00FFFF);
        sample_at(24'shFFFFFF, 24'sh010000);
        set_modes(BORDER_MIRROR, FILTER_BILINEAR, 9'd256, 9'd256);
        sample_at(24'sh018000, 24'shFE8000);   // odd cells flip
        sample_at(24'sh010000, 24'sh020000);
        sample_at(24'sh7FFFFF, 24'sh800000);
        set_modes(BORDER_CLAMP, FILTER_BILINEAR, 9'd0, 9'd511);   // size saturation
        sample_at(24'shFFFFFF, 24'sh010001);
        sample_at(24'sh008000, 24'sh008000);
        set_modes(2'd3, FILTER_NEAREST, 9'd1, 9'd256);   // unused mode acts as clamp
        sample_at(24'sh800000, 24'sh7FFFFF);
        sample_at(24'sh010000, 24'sh00C000);
        set_modes(BORDER_CLAMP, FILTER_BILINEAR, 9'd2, 9'd3);
        write_texel(200, 200, 48'hFFFF_0000_FFFF);   // beyond image size
        sample_at(24'sh010000, 24'sh010000);
        sample_at(24'sh00FFFF, 24'sh000001);
    endtask

    task automatic test_random(int n);
        logic [8:0] sizes [6] = '{9'd0, 9'd1, 9'd2, 9'd5, 9'd15, 9'd16};
        for (int ph = 0; ph < 8; ph++) begin
            set_modes(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, REGION))
                                                  : sizes[$urandom_range(0, 5)],
                      ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, REGION))
                                                  : sizes[$urandom_range(0, 5)]);
            rsp_stall_max = (ph % 3 == 0) ? 0 : 3;
            no_gaps = (ph % 4 == 1);
            for (int i = 0; i < n / 8; i++) begin
                if ($urandom_range(0, 4) == 0)
                    write_texel($urandom_range(0, 255), $urandom_range(0, 255), rand_rgb());
                else
                    sample_at(rand_coord(), rand_coord());
            end
            no_gaps = 1'b0;
        end
    endtask

    initial begin
        req.valid = 1'b0;
        req.op = OP_WRITE;
        req.texel_x = '0;
        req.texel_y = '0;
        req.texel_red = '0;
        req.texel_green = '0;
        req.texel_blue = '0;
        req.coord_u = '0;
        req.coord_v = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_fill_store();
        test_directed();
        test_random(1120);
        drain();
        repeat (20) @(negedge clk);
        if (errors == 0 && expected_rgb.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // run limit: every request under long gaps and stalls, several times over
    initial begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
